// ===== rtl/spk_pkg.sv =====
// shared types, register indexes and round functions for the speck32/64 unit
// no dependencies; used by speck_block_cipher_unit
package spk_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RcW    = 5;

  typedef logic [WordW-1:0] word_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_0  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_1  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_2  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_3  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROUND_COUNT = 3'd4;

  localparam logic [RcW-1:0] RoundCountReset = 5'd22;

  // operation codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef struct packed {
    word_t x;
    word_t y;
  } blk_t;

  function automatic word_t ror7(input word_t v);
    return {v[6:0], v[15:7]};
  endfunction

  function automatic word_t rol7(input word_t v);
    return {v[8:0], v[15:9]};
  endfunction

  function automatic word_t ror2(input word_t v);
    return {v[1:0], v[15:2]};
  endfunction

  function automatic word_t rol2(input word_t v);
    return {v[13:0], v[15:14]};
  endfunction

  function automatic blk_t enc_round(input word_t x, input word_t y, input word_t k);
    blk_t r;
    r.x = (ror7(x) + y) ^ k;
    r.y = rol2(y) ^ r.x;
    return r;
  endfunction

  function automatic blk_t dec_round(input word_t x, input word_t y, input word_t k);
    blk_t r;
    r.y = ror2(y ^ x);
    r.x = rol7((x ^ k) - r.y);
    return r;
  endfunction

endpackage

// ===== rtl/spk_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module spk_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 22
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/speck_block_cipher_unit.sv =====
// speck32/64 encrypt/decrypt unit, one shared round datapath, round keys in spk_ram
// a transfer runs n = min(round_count, MAX_ROUNDS) rounds, one key read a round, then loads the result;
// a round count of zero passes the block through to the result unchanged
// the single round unit takes a new block only after the last one is loaded into the output registers
// after reset and after every key word write the schedule fills the key ram, input stalled
// meanwhile; key words reset to 0, round_count to 22
module speck_block_cipher_unit #(
  parameter int unsigned MAX_ROUNDS = 22
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [spk_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [spk_pkg::WordW-1:0]   cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [spk_pkg::WordW-1:0]   block_left_i,
  input  logic [spk_pkg::WordW-1:0]   block_right_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spk_pkg::WordW-1:0]   result_left_o,
  output logic [spk_pkg::WordW-1:0]   result_right_o
);

  localparam int unsigned AW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  // configuration registers
  spk_pkg::word_t             key_q [4];
  logic [spk_pkg::RcW-1:0]    rc_q;
  logic                       key_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
      rc_q     <= spk_pkg::RoundCountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spk_pkg::REG_KEY_WORD_0:  key_q[0] <= cfg_wdata_i;
        spk_pkg::REG_KEY_WORD_1:  key_q[1] <= cfg_wdata_i;
        spk_pkg::REG_KEY_WORD_2:  key_q[2] <= cfg_wdata_i;
        spk_pkg::REG_KEY_WORD_3:  key_q[3] <= cfg_wdata_i;
        spk_pkg::REG_ROUND_COUNT: rc_q     <= cfg_wdata_i[spk_pkg::RcW-1:0];
        default: ;
      endcase
    end
  end

  assign key_wr = cfg_we_i && (cfg_idx_i == spk_pkg::REG_KEY_WORD_0 ||
                               cfg_idx_i == spk_pkg::REG_KEY_WORD_1 ||
                               cfg_idx_i == spk_pkg::REG_KEY_WORD_2 ||
                               cfg_idx_i == spk_pkg::REG_KEY_WORD_3);

  // key schedule sequencer
  logic           busy_q, busy_d;
  logic           load_q, load_d;
  logic [AW-1:0]  kcnt_q, kcnt_d;
  spk_pkg::word_t cur_q, cur_d;
  spk_pkg::word_t sch_q [3];
  spk_pkg::word_t sch_d [3];
  spk_pkg::word_t nl;
  spk_pkg::word_t cur_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  spk_pkg::word_t ram_wdata;

  assign nl      = (cur_q + spk_pkg::ror7(sch_q[0])) ^ spk_pkg::word_t'(kcnt_q);
  assign cur_nxt = spk_pkg::rol2(cur_q) ^ nl;

  always_comb begin
    busy_d    = busy_q;
    load_d    = 1'b0;
    kcnt_d    = kcnt_q;
    cur_d     = cur_q;
    sch_d     = sch_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q[0];
    if (load_q) begin
      // round key 0 is key word 0 itself
      cur_d     = key_q[0];
      sch_d[0]  = key_q[1];
      sch_d[1]  = key_q[2];
      sch_d[2]  = key_q[3];
      kcnt_d    = '0;
      ram_we    = 1'b1;
      busy_d    = (MAX_ROUNDS > 1);
    end else if (busy_q) begin
      // schedule words rotate so the next one used is always at the head
      sch_d[0]  = sch_q[1];
      sch_d[1]  = sch_q[2];
      sch_d[2]  = nl;
      cur_d     = cur_nxt;
      kcnt_d    = kcnt_q + AW'(1);
      ram_we    = 1'b1;
      ram_waddr = kcnt_q + AW'(1);
      ram_wdata = cur_nxt;
      if (kcnt_q == AW'(MAX_ROUNDS - 2)) begin
        busy_d = 1'b0;
      end
    end
    if (key_wr) begin
      busy_d = 1'b1;
      load_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      load_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
      load_q <= load_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kcnt_q <= kcnt_d;
    cur_q  <= cur_d;
    sch_q  <= sch_d;
  end

  // round key memory
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  spk_pkg::word_t ram_rdata;

  spk_ram #(
    .WIDTH (spk_pkg::WordW),
    .DEPTH (MAX_ROUNDS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // round datapath
  logic [1:0]     st_q, st_d;
  logic           cmd_q, cmd_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  rnd_q, rnd_d;
  logic [AW-1:0]  addr_q, addr_d;
  spk_pkg::word_t x_q, x_d, y_q, y_d;

  logic           out_valid_q;
  spk_pkg::word_t out_x_q, out_y_q;
  logic           out_free;
  logic           out_load;
  spk_pkg::word_t out_x, out_y;

  logic           in_xfer;
  logic [CW-1:0]  n_eff;
  logic [CW-1:0]  n_m1;
  logic           last;
  spk_pkg::blk_t  rb;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || (st_q != ST_IDLE);
  assign in_xfer  = in_valid_i && !in_stall_o;

  assign n_eff = (rc_q > spk_pkg::RcW'(MAX_ROUNDS)) ? CW'(MAX_ROUNDS) : CW'(rc_q);
  assign n_m1  = n_eff - CW'(1);
  assign last  = (rnd_q == n_q - CW'(1));
  assign rb    = (cmd_q == spk_pkg::CMD_DECRYPT) ? spk_pkg::dec_round(x_q, y_q, ram_rdata)
                                                 : spk_pkg::enc_round(x_q, y_q, ram_rdata);

  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    n_d       = n_q;
    rnd_d     = rnd_q;
    addr_d    = addr_q;
    x_d       = x_q;
    y_d       = y_q;
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    out_load  = 1'b0;
    out_x     = x_q;
    out_y     = y_q;
    case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d = cmd_i;
          n_d   = n_eff;
          rnd_d = '0;
          x_d   = block_left_i;
          y_d   = block_right_i;
          if (n_eff == '0) begin
            // no rounds: block passes through
            if (out_free) begin
              out_load = 1'b1;
              out_x    = block_left_i;
              out_y    = block_right_i;
            end else begin
              st_d = ST_HOLD;
            end
          end else begin
            // decryption walks the keys from the last one in use down
            ram_re    = 1'b1;
            ram_raddr = (cmd_i == spk_pkg::CMD_DECRYPT) ? AW'(n_m1) : '0;
            addr_d    = ram_raddr;
            st_d      = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        x_d = rb.x;
        y_d = rb.y;
        if (last) begin
          if (out_free) begin
            out_load = 1'b1;
            out_x    = rb.x;
            out_y    = rb.y;
            st_d     = ST_IDLE;
          end else begin
            st_d = ST_HOLD;
          end
        end else begin
          rnd_d     = rnd_q + CW'(1);
          ram_re    = 1'b1;
          ram_raddr = (cmd_q == spk_pkg::CMD_DECRYPT) ? addr_q - AW'(1) : addr_q + AW'(1);
          addr_d    = ram_raddr;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    n_q    <= n_d;
    rnd_q  <= rnd_d;
    addr_q <= addr_d;
    x_q    <= x_d;
    y_q    <= y_d;
    if (out_load) begin
      out_x_q <= out_x;
      out_y_q <= out_y;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_left_o  = out_x_q;
  assign result_right_o = out_y_q;

`ifndef SYNTHESIS
  a_no_xfer_in_sched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("input transfer while key schedule runs");

  a_ram_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("key ram written and read in the same cycle");

  a_round_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (n_q != '0 && rnd_q < n_q))
    else $error("round counter out of range");

  a_round_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN && !last) |=> (st_q == ST_RUN && rnd_q == $past(rnd_q) + CW'(1)))
    else $error("round counter did not advance");

  a_hold_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN && last && !out_free) |=> (st_q == ST_HOLD && out_valid_q))
    else $error("finished block lost while output stalled");
`endif

endmodule

// ===== tb/speck_block_cipher_unit_tb.sv =====
// self-checking testbench for speck_block_cipher_unit (speck32/64 encrypt/decrypt)
// uses spk_pkg for types, register indexes and command codes; holds its own cipher model
`timescale 1ns / 1ps

module speck_block_cipher_unit_tb;

  localparam int NumRounds   = 22;
  localparam int SegItems    = 155;
  localparam int HoldCycles  = 400;
  localparam int StuckLimit  = 4000;
  localparam int RegIdxLast  = (1 << spk_pkg::CfgIdxW) - 1;
  localparam logic [spk_pkg::CfgIdxW-1:0] RegUnusedFirst = spk_pkg::REG_ROUND_COUNT + 3'd1;

  localparam logic [63:0] KeyZero   = 64'h0;
  localparam logic [63:0] KeyOnes   = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KeyVector = 64'h1918_1110_0908_0100;

  typedef struct packed {
    logic [63:0]             key;
    logic [spk_pkg::RcW-1:0] rounds;
    logic                    junk_writes;
    logic                    op;
    spk_pkg::word_t          left;
    spk_pkg::word_t          right;
    logic                    typed;
    spk_pkg::word_t          exp_left;
    spk_pkg::word_t          exp_right;
  } dir_row_t;

  // known-answer rows carry their result, the rest go through the model
  localparam dir_row_t DirRows [16] = '{
    '{KeyZero,   5'd22, 1'b0, spk_pkg::CMD_ENCRYPT, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{KeyZero,   5'd22, 1'b0, spk_pkg::CMD_ENCRYPT, 16'hffff, 16'hffff, 1'b0, 16'h0, 16'h0},
    '{KeyZero,   5'd22, 1'b0, spk_pkg::CMD_DECRYPT, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{KeyZero,   5'd22, 1'b0, spk_pkg::CMD_DECRYPT, 16'hffff, 16'hffff, 1'b0, 16'h0, 16'h0},
    '{KeyZero,   5'd22, 1'b0, spk_pkg::CMD_ENCRYPT, 16'h8000, 16'h0001, 1'b0, 16'h0, 16'h0},
    '{KeyVector, 5'd22, 1'b0, spk_pkg::CMD_ENCRYPT, 16'h6574, 16'h694c, 1'b1, 16'ha868, 16'h42f2},
    '{KeyVector, 5'd22, 1'b0, spk_pkg::CMD_DECRYPT, 16'ha868, 16'h42f2, 1'b1, 16'h6574, 16'h694c},
    '{KeyVector, 5'd23, 1'b0, spk_pkg::CMD_ENCRYPT, 16'h6574, 16'h694c, 1'b1, 16'ha868, 16'h42f2},
    '{KeyVector, 5'd31, 1'b0, spk_pkg::CMD_DECRYPT, 16'ha868, 16'h42f2, 1'b1, 16'h6574, 16'h694c},
    '{KeyVector, 5'd0,  1'b0, spk_pkg::CMD_ENCRYPT, 16'h1234, 16'habcd, 1'b1, 16'h1234, 16'habcd},
    '{KeyVector, 5'd0,  1'b0, spk_pkg::CMD_DECRYPT, 16'hffff, 16'h0000, 1'b1, 16'hffff, 16'h0000},
    '{KeyOnes,   5'd1,  1'b0, spk_pkg::CMD_ENCRYPT, 16'hffff, 16'hffff, 1'b0, 16'h0, 16'h0},
    '{KeyOnes,   5'd1,  1'b0, spk_pkg::CMD_DECRYPT, 16'h0000, 16'hffff, 1'b0, 16'h0, 16'h0},
    '{KeyOnes,   5'd22, 1'b0, spk_pkg::CMD_ENCRYPT, 16'h0001, 16'h8000, 1'b0, 16'h0, 16'h0},
    '{KeyOnes,   5'd22, 1'b0, spk_pkg::CMD_DECRYPT, 16'hffff, 16'hffff, 1'b0, 16'h0, 16'h0},
    '{KeyVector, 5'd22, 1'b1, spk_pkg::CMD_ENCRYPT, 16'h6574, 16'h694c, 1'b1, 16'ha868, 16'h42f2}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [spk_pkg::CfgIdxW-1:0] cfg_idx = '0;
  spk_pkg::word_t              cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        cmd = spk_pkg::CMD_ENCRYPT;
  spk_pkg::word_t              block_left = '0;
  spk_pkg::word_t              block_right = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  spk_pkg::word_t              result_left;
  spk_pkg::word_t              result_right;

  // cipher model state
  spk_pkg::word_t          key_words [4];
  logic [spk_pkg::RcW-1:0] rounds_reg;
  spk_pkg::word_t          round_keys [NumRounds];

  spk_pkg::blk_t expected_blocks [$];
  spk_pkg::blk_t head_block;
  int   src_idle_pct = 19;
  int   sink_stall_pct = 74;
  int   blocks_sent = 0;
  int   results_checked = 0;
  int   mismatches = 0;
  int   stuck_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  speck_block_cipher_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .block_left_i   (block_left),
    .block_right_i  (block_right),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_left_o  (result_left),
    .result_right_o (result_right)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic spk_pkg::word_t rotr(spk_pkg::word_t v, int n);
    return (v >> n) | (v << (spk_pkg::WordW - n));
  endfunction

  function automatic spk_pkg::word_t rotl(spk_pkg::word_t v, int n);
    return (v << n) | (v >> (spk_pkg::WordW - n));
  endfunction

  function automatic void expand_round_keys();
    spk_pkg::word_t l_words [3];
    spk_pkg::word_t k_cur;
    spk_pkg::word_t l_new;
    l_words[0] = key_words[1];
    l_words[1] = key_words[2];
    l_words[2] = key_words[3];
    k_cur = key_words[0];
    round_keys[0] = k_cur;
    for (int i = 0; i < NumRounds - 1; i++) begin
      l_new = (k_cur + rotr(l_words[i % 3], 7)) ^ spk_pkg::word_t'(i);
      l_words[i % 3] = l_new;
      k_cur = rotl(k_cur, 2) ^ l_new;
      round_keys[i + 1] = k_cur;
    end
  endfunction

  function automatic spk_pkg::blk_t crypt_block(logic op, spk_pkg::word_t left,
                                                spk_pkg::word_t right);
    spk_pkg::blk_t b;
    int            n;
    // counts past the schedule length saturate
    n = (int'(rounds_reg) > NumRounds) ? NumRounds : int'(rounds_reg);
    b.x = left;
    b.y = right;
    if (op == spk_pkg::CMD_ENCRYPT) begin
      for (int i = 0; i < n; i++) begin
        b.x = (rotr(b.x, 7) + b.y) ^ round_keys[i];
        b.y = rotl(b.y, 2) ^ b.x;
      end
    end else begin
      for (int i = n; i > 0; i--) begin
        b.y = rotr(b.y ^ b.x, 2);
        b.x = rotl((b.x ^ round_keys[i - 1]) - b.y, 7);
      end
    end
    return b;
  endfunction

  function automatic spk_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return spk_pkg::word_t'(1) << $urandom_range(0, spk_pkg::WordW - 1);
      default: return spk_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [spk_pkg::CfgIdxW-1:0] idx, spk_pkg::word_t data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      spk_pkg::REG_KEY_WORD_0, spk_pkg::REG_KEY_WORD_1,
      spk_pkg::REG_KEY_WORD_2, spk_pkg::REG_KEY_WORD_3: begin
        key_words[idx] = data;
        expand_round_keys();
      end
      spk_pkg::REG_ROUND_COUNT: rounds_reg = data[spk_pkg::RcW-1:0];
      default: ;  // unused indexes are dropped
    endcase
  endtask

  // upper bits of the round count write are noise the block must drop
  task automatic program_cipher(logic [63:0] key, logic [spk_pkg::RcW-1:0] rounds);
    write_reg(spk_pkg::REG_KEY_WORD_0, key[15:0]);
    write_reg(spk_pkg::REG_KEY_WORD_1, key[31:16]);
    write_reg(spk_pkg::REG_KEY_WORD_2, key[47:32]);
    write_reg(spk_pkg::REG_KEY_WORD_3, key[63:48]);
    write_reg(spk_pkg::REG_ROUND_COUNT,
              {(spk_pkg::WordW - spk_pkg::RcW)'($urandom), rounds});
  endtask

  task automatic send_block(logic op, spk_pkg::word_t left, spk_pkg::word_t right,
                            spk_pkg::blk_t expect_blk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    block_left <= left;
    block_right <= right;
    do @(posedge clk); while (in_stall);
    expected_blocks.push_back(expect_blk);
    blocks_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_blocks.size() != 0);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (NumRounds + 2) @(posedge clk);
  endtask

  task automatic set_idling(int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result transfer: left %h right %h", result_left, result_right);
        mismatches++;
      end else begin
        head_block = expected_blocks.pop_front();
        if (result_left !== head_block.x) begin
          $error("result_left: expected %h, got %h", head_block.x, result_left);
          mismatches++;
        end
        if (result_right !== head_block.y) begin
          $error("result_right: expected %h, got %h", head_block.y, result_right);
          mismatches++;
        end
        results_checked++;
      end
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("timeout: no transfer for %0d cycles", StuckLimit);
      $display("speck_block_cipher_unit: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    dir_row_t                row;
    spk_pkg::blk_t           expect_blk;
    logic [63:0]             seg_key;
    logic [spk_pkg::RcW-1:0] seg_rounds;
    logic                    op;
    spk_pkg::word_t          left;
    spk_pkg::word_t          right;

    key_words = '{default: '0};
    rounds_reg = spk_pkg::RoundCountReset;
    expand_round_keys();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirRows[i]) begin
      row = DirRows[i];
      if (row.key != {key_words[3], key_words[2], key_words[1], key_words[0]} ||
          row.rounds != rounds_reg || row.junk_writes) begin
        wait_idle();
        program_cipher(row.key, row.rounds);
        if (row.junk_writes) begin
          for (int j = RegUnusedFirst; j <= RegIdxLast; j++) begin
            write_reg(j[spk_pkg::CfgIdxW-1:0], spk_pkg::word_t'($urandom));
          end
        end
        cfg_we <= 1'b0;
      end
      if (row.typed) begin
        expect_blk.x = row.exp_left;
        expect_blk.y = row.exp_right;
      end else begin
        expect_blk = crypt_block(row.op, row.left, row.right);
      end
      send_block(row.op, row.left, row.right, expect_blk);
    end

    for (int s = 0; s < 6; s++) begin
      wait_idle();
      if (s == 2) set_idling(74, 19);
      if (s == 4) set_idling(0, 0);
      seg_key = {$urandom, $urandom};
      case (s)
        0: seg_rounds = 5'd22;
        1: begin
          seg_key = KeyOnes;
          seg_rounds = 5'd1;
        end
        2: seg_rounds = spk_pkg::RcW'($urandom_range(2, 21));
        3: begin
          seg_key = KeyZero;
          seg_rounds = '0;
        end
        4: seg_rounds = spk_pkg::RcW'($urandom_range(23, 31));
        default: seg_rounds = 5'd22;
      endcase
      program_cipher(seg_key, seg_rounds);
      cfg_we <= 1'b0;
      // long receiver hold while items keep coming, so the unit backs up
      if (s == 1) hold_req <= 1'b1;
      for (int k = 0; k < SegItems; k++) begin
        if (k == SegItems / 2) wait_results();
        op = $urandom_range(0, 1) ? spk_pkg::CMD_DECRYPT : spk_pkg::CMD_ENCRYPT;
        left = pick_word();
        right = pick_word();
        send_block(op, left, right, crypt_block(op, left, right));
      end
    end

    wait_results();
    repeat (2 * NumRounds) @(posedge clk);
    $display("%0d blocks sent, %0d results checked, %0d mismatches",
             blocks_sent, results_checked, mismatches);
    $display("covered encrypt/decrypt, known answers, zero/one/full/saturated rounds, stalls");
    if (mismatches == 0) begin
      $display("speck_block_cipher_unit: match");
    end else begin
      $display("speck_block_cipher_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== speck_block_cipher_unit.f =====
rtl/spk_pkg.sv
rtl/spk_ram.sv
rtl/speck_block_cipher_unit.sv
tb/speck_block_cipher_unit_tb.sv
